[hdl/stable_two_key_sorter_assert.svh]
// Assertion helpers shared by the sorter modules.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef STABLE_TWO_KEY_SORTER_ASSERT_SVH
`define STABLE_TWO_KEY_SORTER_ASSERT_SVH

// Same-cycle implication.
`define STS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sorter check failed");

// Next-cycle implication.
`define STS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sorter check failed");

`endif

[hdl/sts_pkg.sv]
package sts_pkg;

    localparam int LAYER_W  = 16;
    localparam int BRANCH_W = 10;
    localparam int TAG_W    = 16;
    localparam int KEY_W    = LAYER_W + BRANCH_W;

    typedef struct packed {
        logic [LAYER_W-1:0]  layer;
        logic [BRANCH_W-1:0] branch;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    typedef enum logic {
        S_COLLECT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic insert;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic one_left;
        logic empty;
    } t_dp_status;

endpackage

[hdl/sts_item_if.sv]
interface sts_item_if;
    logic                         valid;
    logic                         ready;
    logic [sts_pkg::LAYER_W-1:0]  layer_number;
    logic [sts_pkg::BRANCH_W-1:0] branch_number;
    logic [sts_pkg::TAG_W-1:0]    item_tag;
    logic                         batch_end;

    modport source (
        output valid, layer_number, branch_number, item_tag, batch_end,
        input  ready
    );
    modport sink (
        input  valid, layer_number, branch_number, item_tag, batch_end,
        output ready
    );
endinterface

[hdl/sts_result_if.sv]
interface sts_result_if;
    logic                         valid;
    logic                         ready;
    logic [sts_pkg::LAYER_W-1:0]  out_layer;
    logic [sts_pkg::BRANCH_W-1:0] out_branch;
    logic [sts_pkg::TAG_W-1:0]    out_tag;
    logic                         out_final;
    logic                         overflowed;

    modport source (
        output valid, out_layer, out_branch, out_tag, out_final, overflowed,
        input  ready
    );
    modport sink (
        input  valid, out_layer, out_branch, out_tag, out_final, overflowed,
        output ready
    );
endinterface

[hdl/sts_datapath.sv]
`include "stable_two_key_sorter_assert.svh"

module sts_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sts_pkg::t_dp_cmd             i_cmd,
    output sts_pkg::t_dp_status          o_status,
    input  sts_pkg::t_entry              i_entry,
    output logic [sts_pkg::LAYER_W-1:0]  o_out_layer,
    output logic [sts_pkg::BRANCH_W-1:0] o_out_branch,
    output logic [sts_pkg::TAG_W-1:0]    o_out_tag,
    output logic                         o_out_final,
    output logic                         o_overflowed
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    sts_pkg::t_entry r_row [MAX_ITEMS];
    sts_pkg::t_entry n_row [MAX_ITEMS];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;

    logic [MAX_ITEMS-1:0]   greater;
    logic [MAX_ITEMS-1:0]   greater_prev;
    logic [sts_pkg::KEY_W-1:0] new_key;
    logic                   full;

    assign new_key = {i_entry.layer, i_entry.branch};
    assign full    = (r_count == CNT_W'(MAX_ITEMS));

    // One comparator per cell; the flags are monotonic over a sorted row.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            greater[i] = (CNT_W'(i) < r_count) &&
                         ({r_row[i].layer, r_row[i].branch} > new_key);
        end
    end

    assign greater_prev = {greater[MAX_ITEMS-2:0], 1'b0};

    always_comb begin
        n_row   = r_row;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.insert) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                for (int i = 0; i < MAX_ITEMS; i++) begin
                    if (greater_prev[i]) begin
                        n_row[i] = r_row[(i == 0) ? 0 : i - 1];
                    end else if (greater[i] || CNT_W'(i) == r_count) begin
                        n_row[i] = i_entry;
                    end
                end
            end
        end else if (i_cmd.emit) begin
            // Advance the row toward the head by one cell.
            for (int i = 0; i < MAX_ITEMS - 1; i++) begin
                n_row[i] = r_row[i + 1];
            end
            n_count = r_count - 1'b1;
            if (r_count == CNT_W'(1)) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_layer  <= r_row[0].layer;
            o_out_branch <= r_row[0].branch;
            o_out_tag    <= r_row[0].tag;
            o_out_final  <= (r_count == CNT_W'(1));
            o_overflowed <= r_ovf;
        end
    end

    assign o_status.one_left = (r_count == CNT_W'(1));
    assign o_status.empty    = (r_count == '0);

    `STS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ITEMS))
    `STS_ASSERT_NOW(a_emit_nonempty, i_cmd.emit, r_count != '0)

endmodule

[hdl/sts_ctrl.sv]
`include "stable_two_key_sorter_assert.svh"

module sts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_batch_end,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sts_pkg::t_dp_cmd    o_cmd,
    input  sts_pkg::t_dp_status i_status
);

    sts_pkg::t_state r_state;
    sts_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;
    logic            slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sts_pkg::S_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.emit   = 1'b0;
        accept       = 1'b0;
        unique case (r_state)
            sts_pkg::S_COLLECT: begin
                o_in_ready   = 1'b1;
                accept       = i_in_valid;
                o_cmd.insert = accept;
                if (accept && i_batch_end) begin
                    n_state = sts_pkg::S_EMIT;
                end
            end
            sts_pkg::S_EMIT: begin
                o_cmd.emit = slot_free;
                if (slot_free && i_status.one_left) begin
                    n_state = sts_pkg::S_COLLECT;
                end
            end
            default: begin
                n_state = sts_pkg::S_COLLECT;
            end
        endcase
        // Hold the result until the sink takes it.
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `STS_ASSERT_NOW(a_cmd_excl, o_cmd.insert, !o_cmd.emit)
    `STS_ASSERT_NEXT(a_end_starts_emit, accept && i_batch_end, r_state == sts_pkg::S_EMIT)
    `STS_ASSERT_NEXT(a_last_emit_returns, o_cmd.emit && i_status.one_left,
                     r_state == sts_pkg::S_COLLECT && r_out_valid)
    `STS_ASSERT_NOW(a_emit_has_data, r_state == sts_pkg::S_EMIT, !i_status.empty)

endmodule

[hdl/stable_two_key_sorter.sv]
// Stable two-key sorter: collects a batch of items, one transfer per cycle, into
// a row of MAX_ITEMS cells kept sorted by layer number and then branch number,
// with equal keys in arrival order. Each cell compares its key to the incoming
// one in parallel. The transfer that carries batch_end is inserted too and starts
// emission: the row shifts toward its head one result per cycle while the output
// register is free. No items are taken during emission; the next batch may begin
// as soon as the last result sits in the output register. Items beyond MAX_ITEMS
// are dropped and every result of that batch carries overflowed; out_final marks
// the last result of the batch.
module stable_two_key_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sts_item_if.sink         i_item,
    sts_result_if.source     o_result
);

    sts_pkg::t_dp_cmd    cmd;
    sts_pkg::t_dp_status status;
    sts_pkg::t_entry     entry;

    assign entry.layer  = i_item.layer_number;
    assign entry.branch = i_item.branch_number;
    assign entry.tag    = i_item.item_tag;

    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_batch_end (i_item.batch_end),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sts_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_entry      (entry),
        .o_out_layer  (o_result.out_layer),
        .o_out_branch (o_result.out_branch),
        .o_out_tag    (o_result.out_tag),
        .o_out_final  (o_result.out_final),
        .o_overflowed (o_result.overflowed)
    );

endmodule
